// ----- hw/rtl/clp_pkg.sv -----
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants of the command line parser
// Holds parse phases, parameter kinds, status codes, character codes and the
// record type that the parse stage hands to the output stage.
// ----------------------------------------------------------------------------
package clp_pkg;

    // Maximum bytes of one line, line feed included.
    localparam logic [7:0] LINE_MAX    = 8'd128;
    // Maximum characters inside a quoted string.
    localparam logic [6:0] STRING_MAX  = 7'd64;
    // Maximum fraction digits of a decimal parameter.
    localparam logic [1:0] FRAC_DIGITS = 2'd2;

    // Largest magnitude kept by the number accumulator.
    localparam logic [34:0] MAG_LIMIT  = 35'h0_8000_0000;
    localparam logic [31:0] MAG_NEG    = 32'h8000_0000;
    localparam logic [31:0] MAG_POS    = 32'h7FFF_FFFF;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [3:0] {
        PH_CMD1        = 4'd0,
        PH_CMD2        = 4'd1,
        PH_AFTER_CMD   = 4'd2,
        PH_PSTART      = 4'd3,
        PH_SIGN        = 4'd4,
        PH_INT         = 4'd5,
        PH_FRAC        = 4'd6,
        PH_STRING      = 4'd7,
        PH_AFTER_PARAM = 4'd8,
        PH_ERROR       = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_INT    = 3'd1,
        KIND_DEC    = 3'd2,
        KIND_LETTER = 3'd3,
        KIND_STRING = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [6:0]  frac;
    } t_param;

    typedef struct packed {
        logic [6:0] cmd_first;
        logic [6:0] cmd_second;
        t_param     p1;
        t_param     p2;
        t_status    status;
    } t_record;

endpackage

// ----- hw/rtl/clp_if.sv -----
// ----------------------------------------------------------------------------
// clp_if: channel interfaces of the command line parser
// clp_in_if carries one byte per transaction, clp_out_if one line record.
// ----------------------------------------------------------------------------
interface clp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface clp_out_if;
    logic              valid;
    logic              ready;
    logic [6:0]        cmd_first;
    logic [6:0]        cmd_second;
    logic [2:0]        p1_kind;
    logic signed [31:0] p1_value;
    logic [6:0]        p1_frac;
    logic [2:0]        p2_kind;
    logic signed [31:0] p2_value;
    logic [6:0]        p2_frac;
    logic [1:0]        line_status;

    modport source (
        output valid, output cmd_first, output cmd_second,
        output p1_kind, output p1_value, output p1_frac,
        output p2_kind, output p2_value, output p2_frac,
        output line_status, input ready
    );
    modport sink (
        input valid, input cmd_first, input cmd_second,
        input p1_kind, input p1_value, input p1_frac,
        input p2_kind, input p2_value, input p2_frac,
        input line_status, output ready
    );
endinterface

// ----- hw/rtl/command_line_parser.sv -----
// ----------------------------------------------------------------------------
// command_line_parser: host command line parser, top level
// Parses a two-letter command with up to two parameters, one byte at a time,
// and returns one record per line.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle on i_in and returns one record on
// o_out for every line feed; other bytes produce no record. A byte is held in
// the input register and advanced through the parse step in the cycle after
// its transaction; for a line feed the record is written into the output
// register at the end of that same cycle, so a record is offered on o_out in the
// cycle after its line feed left the parse step. The sustained rate is one byte per
// cycle, set by the single parse step, whose longest path is the times-ten
// accumulate of the number register. Bytes keep flowing while a record waits
// in the output register; only a second line feed waits until the sink has
// taken the earlier record. Command letters are folded to upper case,
// integers saturate to the 32-bit signed range, a decimal reports its integer
// part and up to FRAC_DIGITS fraction digits as accumulated, and a quoted
// string of at most STRING_MAX bytes reports only its length. A line holds at
// most LINE_MAX bytes, line feed included. The first error on a line is kept
// in line_status and later bytes of that line are only counted.
// ----------------------------------------------------------------------------
module command_line_parser #(
    parameter logic [7:0] LINE_MAX    = clp_pkg::LINE_MAX,
    parameter logic [6:0] STRING_MAX  = clp_pkg::STRING_MAX,
    parameter logic [1:0] FRAC_DIGITS = clp_pkg::FRAC_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clp_in_if.sink     i_in,
    clp_out_if.source  o_out
);
    import clp_pkg::*;

    // Byte handed from the input register to the parse step.
    logic       byte_valid;
    logic [7:0] byte_char;
    logic       byte_take;

    // Record handed from the parse step to the output register.
    logic       rec_valid;
    t_record    rec;
    logic       out_room;

    clp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (byte_take),
        .o_valid (byte_valid),
        .o_char  (byte_char)
    );

    // The parse step takes a line feed only when the output register has room,
    // so a finished record is never overwritten.
    clp_parse #(
        .LINE_MAX    (LINE_MAX),
        .STRING_MAX  (STRING_MAX),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .i_char      (byte_char),
        .i_out_room  (out_room),
        .o_take      (byte_take),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    clp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .o_room      (out_room),
        .o_out       (o_out)
    );
endmodule

// ----- hw/rtl/clp_in_stage.sv -----
// ----------------------------------------------------------------------------
// clp_in_stage: input register of the command line parser
// Captures one byte per transaction and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
module clp_in_stage (
    input  logic   i_clk,
    input  logic   i_rst_n,
    clp_in_if.sink i_in,
    input  logic   i_take,
    output logic   o_valid,
    output logic [7:0] o_char
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_char;
    logic       accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign n_valid    = accept || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_in.char_in;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
endmodule

// ----- hw/rtl/clp_parse.sv -----
// ----------------------------------------------------------------------------
// clp_parse: per-byte parse step of the command line parser
// Holds the line state and advances it by one byte per cycle, a line feed only
// with output room; on line feed it assembles the record and clears the state.
// ----------------------------------------------------------------------------
module clp_parse #(
    parameter logic [7:0] LINE_MAX    = clp_pkg::LINE_MAX,
    parameter logic [6:0] STRING_MAX  = clp_pkg::STRING_MAX,
    parameter logic [1:0] FRAC_DIGITS = clp_pkg::FRAC_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_char,
    input  logic        i_out_room,
    output logic        o_take,
    output logic        o_rec_valid,
    output clp_pkg::t_record o_rec
);
    import clp_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_accum,  n_accum;
    logic        r_neg,    n_neg;
    logic [6:0]  r_frac,   n_frac;
    logic [1:0]  r_fcnt,   n_fcnt;
    logic [6:0]  r_scnt,   n_scnt;
    logic [7:0]  r_lcnt,   n_lcnt;
    logic [6:0]  r_let0,   n_let0;
    logic [6:0]  r_let1,   n_let1;
    t_param      r_p1,     n_p1;
    t_param      r_p2,     n_p2;
    t_status     r_error,  n_error;

    logic        is_lf, is_upper, is_lower, is_letter, is_digit, is_legal;
    logic [7:0]  folded;
    logic [3:0]  digit;
    logic        too_long;
    t_phase      cur_phase;
    t_status     err_code;
    t_param      fin_param;
    t_param      new_param;
    logic        store;
    logic [34:0] acc_calc;
    logic [31:0] acc_sat;
    logic [9:0]  frac_calc;

    assign is_lf     = (i_char == CH_LF);
    assign is_upper  = (i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_Z);
    assign is_lower  = (i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_legal  = is_letter || is_digit || (i_char == CH_COMMA) ||
                       (i_char == CH_MINUS) || (i_char == CH_DOT) || (i_char == CH_QUOTE);
    assign folded    = is_lower ? (i_char - CASE_OFFSET) : i_char;
    assign digit     = i_char[3:0];

    assign too_long  = (r_lcnt >= LINE_MAX);
    assign cur_phase = too_long ? PH_ERROR : r_phase;

    // Times-ten accumulate as shift and add, saturated at the magnitude limit.
    assign acc_calc  = {r_accum, 3'b000} + {2'b00, r_accum, 1'b0} + {31'd0, digit};
    assign acc_sat   = (acc_calc > MAG_LIMIT) ? MAG_NEG : acc_calc[31:0];
    assign frac_calc = {r_frac, 3'b000} + {2'b00, r_frac, 1'b0} + {6'd0, digit};

    always_comb begin
        fin_param.kind  = (cur_phase == PH_FRAC) ? KIND_DEC : KIND_INT;
        fin_param.value = r_neg ? (~r_accum + 32'd1) : (r_accum[31] ? MAG_POS : r_accum);
        fin_param.frac  = (cur_phase == PH_FRAC) ? r_frac : 7'd0;
    end

    assign o_take      = i_valid && (!is_lf || i_out_room);
    assign o_rec_valid = o_take && is_lf;

    // Next state: one parse step for the byte in the input register.
    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_neg     = r_neg;
        n_frac    = r_frac;
        n_fcnt    = r_fcnt;
        n_scnt    = r_scnt;
        n_lcnt    = r_lcnt;
        n_let0    = r_let0;
        n_let1    = r_let1;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_error   = r_error;
        err_code  = ST_OK;
        store     = 1'b0;
        new_param = fin_param;

        if (too_long) begin
            err_code = ST_LONG;
        end else begin
            n_lcnt = r_lcnt + 8'd1;
        end

        if (cur_phase != PH_ERROR) begin
            if (is_lf) begin
                case (cur_phase)
                    PH_AFTER_CMD, PH_AFTER_PARAM: begin
                    end
                    PH_INT, PH_FRAC: begin
                        store = 1'b1;
                    end
                    default: begin
                        err_code = ST_SYNTAX;
                    end
                endcase
            end else if (cur_phase == PH_STRING) begin
                if (i_char == CH_QUOTE) begin
                    store     = 1'b1;
                    new_param = '{kind: KIND_STRING, value: {25'd0, r_scnt}, frac: 7'd0};
                end else if (r_scnt >= STRING_MAX) begin
                    err_code = ST_SYNTAX;
                end else begin
                    n_scnt = r_scnt + 7'd1;
                end
            end else if (!is_legal) begin
                err_code = ST_ILLEGAL;
            end else begin
                case (cur_phase)
                    PH_CMD1: begin
                        if (is_letter) begin
                            n_let0  = folded[6:0];
                            n_phase = PH_CMD2;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_CMD2: begin
                        if (is_letter) begin
                            n_let1  = folded[6:0];
                            n_phase = PH_AFTER_CMD;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_AFTER_CMD: begin
                        if (i_char == CH_COMMA) begin
                            n_phase = PH_PSTART;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_PSTART: begin
                        if (is_letter) begin
                            store     = 1'b1;
                            new_param = '{kind: KIND_LETTER, value: {25'd0, folded[6:0]},
                                          frac: 7'd0};
                        end else if (is_digit) begin
                            n_accum = {28'd0, digit};
                            n_neg   = 1'b0;
                            n_frac  = 7'd0;
                            n_fcnt  = 2'd0;
                            n_phase = PH_INT;
                        end else if (i_char == CH_MINUS) begin
                            n_accum = 32'd0;
                            n_neg   = 1'b1;
                            n_frac  = 7'd0;
                            n_fcnt  = 2'd0;
                            n_phase = PH_SIGN;
                        end else if (i_char == CH_QUOTE) begin
                            n_scnt  = 7'd0;
                            n_phase = PH_STRING;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_SIGN: begin
                        if (is_digit) begin
                            n_accum = acc_sat;
                            n_phase = PH_INT;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_INT: begin
                        if (is_digit) begin
                            n_accum = acc_sat;
                        end else if (i_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else if (i_char == CH_COMMA) begin
                            store = 1'b1;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit && (r_fcnt < FRAC_DIGITS)) begin
                            n_frac = frac_calc[6:0];
                            n_fcnt = r_fcnt + 2'd1;
                        end else if (i_char == CH_COMMA) begin
                            store = 1'b1;
                        end else begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    PH_AFTER_PARAM: begin
                        if (i_char != CH_COMMA) begin
                            err_code = ST_SYNTAX;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (store) begin
            if (r_p1.kind == KIND_NONE) begin
                n_p1 = new_param;
            end else begin
                n_p2 = new_param;
            end
            n_phase = PH_AFTER_PARAM;
        end

        // A comma after a complete parameter opens the next one, but only two fit.
        if ((n_phase == PH_AFTER_PARAM) && (cur_phase != PH_ERROR) && !is_lf &&
            (cur_phase != PH_STRING) && (i_char == CH_COMMA)) begin
            if (n_p2.kind != KIND_NONE) begin
                err_code = ST_SYNTAX;
            end else begin
                n_phase = PH_PSTART;
            end
        end

        if (err_code != ST_OK) begin
            n_phase = PH_ERROR;
            if (r_error == ST_OK) begin
                n_error = err_code;
            end
        end
    end

    // Outputs: the record as it stands once the line feed has been applied.
    always_comb begin
        o_rec.cmd_first  = n_let0;
        o_rec.cmd_second = n_let1;
        o_rec.p1         = n_p1;
        o_rec.p2         = n_p2;
        o_rec.status     = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_rec_valid) begin
            r_phase <= PH_CMD1;
            r_accum <= 32'd0;
            r_neg   <= 1'b0;
            r_frac  <= 7'd0;
            r_fcnt  <= 2'd0;
            r_scnt  <= 7'd0;
            r_lcnt  <= 8'd0;
            r_let0  <= 7'd0;
            r_let1  <= 7'd0;
            r_p1    <= '{kind: KIND_NONE, value: 32'd0, frac: 7'd0};
            r_p2    <= '{kind: KIND_NONE, value: 32'd0, frac: 7'd0};
            r_error <= ST_OK;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_neg   <= n_neg;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_scnt  <= n_scnt;
            r_lcnt  <= n_lcnt;
            r_let0  <= n_let0;
            r_let1  <= n_let1;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_error <= n_error;
        end
    end

`ifndef SYNTHESIS
    a_error_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ST_OK) |-> (r_phase == PH_ERROR))
        else $error("error status held outside the error phase");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt <= LINE_MAX))
        else $error("line byte count beyond the line limit");

    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |=> (r_lcnt == 8'd0) && (r_phase == PH_CMD1) &&
                        (r_p1.kind == KIND_NONE) && (r_p2.kind == KIND_NONE))
        else $error("line state not cleared after a line feed");

    a_record_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> i_out_room)
        else $error("record issued while the output register is full");
`endif
endmodule

// ----- hw/rtl/clp_out_stage.sv -----
// ----------------------------------------------------------------------------
// clp_out_stage: result register of the command line parser
// Holds one line record until the sink takes it.
// ----------------------------------------------------------------------------
module clp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rec_valid,
    input  clp_pkg::t_record i_rec,
    output logic            o_room,
    clp_out_if.source       o_out
);
    import clp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_record r_rec;

    assign o_room  = !r_valid || o_out.ready;
    assign n_valid = i_rec_valid || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec_valid) begin
            r_rec <= i_rec;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.cmd_first   = r_rec.cmd_first;
    assign o_out.cmd_second  = r_rec.cmd_second;
    assign o_out.p1_kind     = r_rec.p1.kind;
    assign o_out.p1_value    = r_rec.p1.value;
    assign o_out.p1_frac     = r_rec.p1.frac;
    assign o_out.p2_kind     = r_rec.p2.kind;
    assign o_out.p2_value    = r_rec.p2.value;
    assign o_out.p2_frac     = r_rec.p2.frac;
    assign o_out.line_status = r_rec.status;
endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the command line parser
// Sends whole command lines byte by byte, well-formed ones with random content
// as well as broken lines and noise, and compares every line record that
// comes out against a cycle-free software copy of the parser.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clp_pkg::*;

    // Roughly how many bytes the whole stimulus holds.
    localparam int BYTE_TARGET  = 650;
    // Cycles without any transaction on either channel before the run is
    // declared hung.
    localparam int STALL_LIMIT  = 1000;
    // A record is registered after its line feed is parsed; give it some slack.
    localparam int DRAIN_CYCLES = 8;
    // Legal characters that get dropped into otherwise good lines.
    localparam string MUTATION_CHARS = ",-.\"0aZ";

    logic i_clk;
    logic i_rst_n;

    clp_in_if  in_if ();
    clp_out_if out_if ();

    command_line_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Bytes still to be sent, the line being built, and the records that
    // accepted line feeds have promised but the block has not yet returned.
    logic [7:0] tx_bytes[$];
    logic [7:0] line_buf[$];
    t_record    lines_due[$];

    int      total_bytes;
    int      sent_bytes;
    int      error_count;
    int      records_seen;
    int      stall_cycles;
    logic    byte_taken;
    t_record want_rec;

    // ------------------------------------------------------------------------
    // Parser copy. It mirrors the block's per-line state and is advanced once
    // for every byte transaction that the block accepts.
    // ------------------------------------------------------------------------
    t_phase      cur_phase;
    logic [31:0] num_mag;
    logic        num_neg;
    logic [6:0]  frac_val;
    logic [1:0]  frac_digits;
    logic [6:0]  str_len;
    logic [7:0]  line_len;
    logic [6:0]  cmd_letter[2];
    t_param      param_slot[2];
    t_status     line_err;

    function automatic void clear_line();
        cur_phase     = PH_CMD1;
        num_mag       = '0;
        num_neg       = 1'b0;
        frac_val      = '0;
        frac_digits   = '0;
        str_len       = '0;
        line_len      = '0;
        cmd_letter[0] = '0;
        cmd_letter[1] = '0;
        param_slot[0] = '0;
        param_slot[1] = '0;
        line_err      = ST_OK;
    endfunction

    // Only the first error of a line is kept; parsing stops either way.
    function automatic void flag_error(t_status code);
        if (line_err == ST_OK) begin
            line_err = code;
        end
        cur_phase = PH_ERROR;
    endfunction

    function automatic void store_param(t_kind kind, logic [31:0] value, logic [6:0] frac);
        int slot;
        slot = (param_slot[0].kind == KIND_NONE) ? 0 : 1;
        param_slot[slot].kind  = kind;
        param_slot[slot].value = value;
        param_slot[slot].frac  = frac;
        cur_phase = PH_AFTER_PARAM;
    endfunction

    // The magnitude never exceeds 2^31, so negation alone covers the negative
    // limit, while a positive 2^31 clips to the largest positive value. A
    // negative zero simply comes out as zero.
    function automatic void close_number();
        logic [31:0] v;
        if (num_neg) begin
            v = 32'd0 - num_mag;
        end else if (num_mag >= MAG_NEG) begin
            v = MAG_POS;
        end else begin
            v = num_mag;
        end
        if (cur_phase == PH_FRAC) begin
            store_param(KIND_DEC, v, frac_val);
        end else begin
            store_param(KIND_INT, v, '0);
        end
    endfunction

    function automatic void start_number();
        num_mag     = '0;
        num_neg     = 1'b0;
        frac_val    = '0;
        frac_digits = '0;
    endfunction

    function automatic void push_digit(logic [3:0] d);
        logic [35:0] n;
        n = 36'(num_mag) * 36'd10 + 36'(d);
        num_mag = (n > 36'(MAG_NEG)) ? MAG_NEG : n[31:0];
    endfunction

    function automatic void after_comma();
        if (param_slot[1].kind != KIND_NONE) begin
            flag_error(ST_SYNTAX);
        end else begin
            cur_phase = PH_PSTART;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        logic       is_upper;
        logic       is_lower;
        logic       is_letter;
        logic       is_digit;
        logic [6:0] up;
        logic [3:0] dval;
        is_upper  = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
        is_lower  = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
        is_letter = is_upper || is_lower;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        up        = is_lower ? 7'(c - CASE_OFFSET) : c[6:0];
        dval      = 4'(c - CH_ZERO);

        if (cur_phase == PH_STRING) begin
            // Inside quotes every byte but the closing quote is just counted.
            if (c == CH_QUOTE) begin
                store_param(KIND_STRING, 32'(str_len), '0);
            end else if (str_len >= STRING_MAX) begin
                flag_error(ST_SYNTAX);
            end else begin
                str_len++;
            end
        end else if (!(is_letter || is_digit || c == CH_COMMA || c == CH_MINUS ||
                       c == CH_DOT || c == CH_QUOTE)) begin
            flag_error(ST_ILLEGAL);
        end else begin
            case (cur_phase)
                PH_CMD1: begin
                    if (is_letter) begin
                        cmd_letter[0] = up;
                        cur_phase = PH_CMD2;
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_CMD2: begin
                    if (is_letter) begin
                        cmd_letter[1] = up;
                        cur_phase = PH_AFTER_CMD;
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_AFTER_CMD: begin
                    if (c == CH_COMMA) begin
                        cur_phase = PH_PSTART;
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_PSTART: begin
                    if (is_letter) begin
                        store_param(KIND_LETTER, 32'(up), '0);
                    end else if (is_digit) begin
                        start_number();
                        push_digit(dval);
                        cur_phase = PH_INT;
                    end else if (c == CH_MINUS) begin
                        start_number();
                        num_neg = 1'b1;
                        cur_phase = PH_SIGN;
                    end else if (c == CH_QUOTE) begin
                        str_len = '0;
                        cur_phase = PH_STRING;
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        push_digit(dval);
                        cur_phase = PH_INT;
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_INT: begin
                    if (is_digit) begin
                        push_digit(dval);
                    end else if (c == CH_DOT) begin
                        cur_phase = PH_FRAC;
                    end else if (c == CH_COMMA) begin
                        close_number();
                        after_comma();
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_FRAC: begin
                    if (is_digit && frac_digits < FRAC_DIGITS) begin
                        frac_val = 7'(frac_val * 7'd10 + 7'(dval));
                        frac_digits++;
                    end else if (c == CH_COMMA) begin
                        close_number();
                        after_comma();
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                PH_AFTER_PARAM: begin
                    if (c == CH_COMMA) begin
                        after_comma();
                    end else begin
                        flag_error(ST_SYNTAX);
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // A line may end after the command, after a finished parameter, or in
    // the middle of a number, which then gets closed.
    function automatic void end_of_line();
        case (cur_phase)
            PH_AFTER_CMD, PH_AFTER_PARAM, PH_ERROR: ;
            PH_INT, PH_FRAC: close_number();
            default: flag_error(ST_SYNTAX);
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        t_record rec;
        // The length limit counts the line feed too.
        if (line_len >= LINE_MAX) begin
            flag_error(ST_LONG);
        end else begin
            line_len++;
        end
        if (c == CH_LF) begin
            if (cur_phase != PH_ERROR) begin
                end_of_line();
            end
            rec.cmd_first  = cmd_letter[0];
            rec.cmd_second = cmd_letter[1];
            rec.p1         = param_slot[0];
            rec.p2         = param_slot[1];
            rec.status     = line_err;
            lines_due.push_back(rec);
            clear_line();
        end else if (cur_phase != PH_ERROR) begin
            parse_char(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("record %0d: %s is %0h, expected %0h",
                                      records_seen, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers. A line is built in line_buf and then appended to the
    // send queue as a whole.
    // ------------------------------------------------------------------------
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endfunction

    function automatic void add_digits(int n);
        repeat (n) begin
            line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(25) + ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A));
    endfunction

    function automatic void flush_line();
        foreach (line_buf[i]) begin
            tx_bytes.push_back(line_buf[i]);
        end
        line_buf.delete();
    endfunction

    // One parameter: a letter, an integer (with values right at the
    // saturation boundary now and then), a decimal with up to three fraction
    // digits, or a quoted string of random bytes.
    function automatic void add_param();
        int         pick;
        int         n;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 20) begin
            line_buf.push_back(random_letter());
        end else if (pick < 75) begin
            if ($urandom_range(2) == 0) begin
                line_buf.push_back(CH_MINUS);
            end
            if (pick < 30) begin
                case ($urandom_range(4))
                    0: add_text("2147483647");
                    1: add_text("2147483648");
                    2: add_text("2147483649");
                    3: add_text("4294967296");
                    default: add_text("99999999999");
                endcase
            end else begin
                add_digits($urandom_range(1, (pick < 50) ? 10 : 3));
            end
            if (pick >= 50) begin
                line_buf.push_back(CH_DOT);
                add_digits($urandom_range(0, (pick < 54) ? 3 : 2));
            end
        end else begin
            line_buf.push_back(CH_QUOTE);
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
            repeat (n) begin
                do begin
                    ch = 8'($urandom_range(255));
                end while (ch == CH_QUOTE || ch == CH_LF);
                line_buf.push_back(ch);
            end
            line_buf.push_back(CH_QUOTE);
        end
    endfunction

    // Most lines are well formed; a tenth of them get one byte inserted,
    // dropped or overwritten, and the rest is raw noise.
    function automatic void gen_line();
        int pick;
        int n_params;
        int pos;
        pick = $urandom_range(99);
        if (pick < 90) begin
            if ($urandom_range(29) != 0) begin
                line_buf.push_back(random_letter());
                line_buf.push_back(random_letter());
            end else begin
                repeat ($urandom_range(1)) line_buf.push_back(random_letter());
            end
            n_params = ($urandom_range(24) == 0) ? 3 : $urandom_range(2);
            repeat (n_params) begin
                line_buf.push_back(CH_COMMA);
                add_param();
            end
            if (pick >= 80 && line_buf.size() > 0) begin
                pos = $urandom_range(line_buf.size() - 1);
                case ($urandom_range(2))
                    0: line_buf.insert(pos,
                           MUTATION_CHARS[$urandom_range(MUTATION_CHARS.len() - 1)]);
                    1: line_buf.delete(pos);
                    default: line_buf[pos] = 8'($urandom_range(255));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(255)));
        end
        line_buf.push_back(CH_LF);
        flush_line();
    endfunction

    // A line of exactly the given length, line feed included, made of one
    // long integer that also saturates.
    function automatic void gen_long_line(int total);
        add_text("AB,1");
        add_digits(total - 5);
        line_buf.push_back(CH_LF);
        flush_line();
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver. Works on the falling edge so the block sees stable inputs at
    // the rising edge. A byte stays on the channel until a transaction takes
    // it; only then may the next byte or an idle cycle follow. The idle rates
    // move through three phases by how much of the stimulus has gone out.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int send_idle;
        int recv_idle;
        if (sent_bytes < total_bytes / 3) begin
            send_idle = 24;
            recv_idle = 71;
        end else if (sent_bytes < (2 * total_bytes) / 3) begin
            send_idle = 71;
            recv_idle = 24;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (i_rst_n) begin
            if (!in_if.valid || byte_taken) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_if.valid   <= 1'b1;
                    in_if.char_in <= tx_bytes.pop_front();
                    sent_bytes++;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On every rising edge it checks a completed record transaction
    // against the oldest expected record, feeds an accepted byte to the
    // parser copy, and keeps the stall count for the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken   <= 1'b0;
            stall_cycles <= 0;
        end else begin
            byte_taken <= in_if.valid && in_if.ready;

            if (out_if.valid && out_if.ready) begin
                if (lines_due.size() == 0) begin
                    report_mismatch("record arrived with no line feed outstanding");
                end else begin
                    want_rec = lines_due.pop_front();
                    check_field("cmd_first",   32'(out_if.cmd_first),   32'(want_rec.cmd_first));
                    check_field("cmd_second",  32'(out_if.cmd_second),  32'(want_rec.cmd_second));
                    check_field("p1_kind",     32'(out_if.p1_kind),     32'(want_rec.p1.kind));
                    check_field("p1_value",    out_if.p1_value,         want_rec.p1.value);
                    check_field("p1_frac",     32'(out_if.p1_frac),     32'(want_rec.p1.frac));
                    check_field("p2_kind",     32'(out_if.p2_kind),     32'(want_rec.p2.kind));
                    check_field("p2_value",    out_if.p2_value,         want_rec.p2.value);
                    check_field("p2_frac",     32'(out_if.p2_frac),     32'(want_rec.p2.frac));
                    check_field("line_status", 32'(out_if.line_status), 32'(want_rec.status));
                end
                records_seen++;
            end

            if (in_if.valid && in_if.ready) begin
                predict_byte(in_if.char_in);
            end

            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence: build all stimulus, reset once, wait for the block to
    // drain, then give the verdict.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.char_in = '0;
        out_if.ready  = 1'b0;
        error_count   = 0;
        records_seen  = 0;
        sent_bytes    = 0;
        clear_line();

        // Directed lines: an empty line, an illegal character after the
        // command (with case folding), a negative zero decimal followed by
        // an integer, a string holding a byte with every bit set, and a
        // letter parameter.
        add_text("\n");
        add_text("aZ#\n");
        add_text("Mx,-0.5,9\n");
        add_text("QQ,\"");
        line_buf.push_back(8'hFF);
        add_text("\"\n");
        add_text("ab,k\n");
        flush_line();

        // Random lines, with one line exactly at the length limit and one a
        // byte over it somewhere in the middle.
        while (tx_bytes.size() < BYTE_TARGET / 3) gen_line();
        gen_long_line(128);
        gen_long_line(129);
        while (tx_bytes.size() < BYTE_TARGET) gen_line();
        total_bytes = tx_bytes.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Checked on the falling edge, after all rising-edge updates settled.
        while ((tx_bytes.size() != 0 || in_if.valid || lines_due.size() != 0) &&
               stall_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
        end

        if (stall_cycles >= STALL_LIMIT) begin
            $display("** command_line_parser: FAILED **");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (lines_due.size() != 0) begin
                report_mismatch($sformatf("%0d expected record(s) never arrived",
                                          lines_due.size()));
            end
            if (error_count == 0) begin
                $display("** command_line_parser: PASSED **");
            end else begin
                $display("** command_line_parser: FAILED **");
            end
        end
        $finish;
    end

endmodule
